@@ rtl/lost_pkg.sv @@
package lost_pkg;

  localparam int unsigned COLUMN_BITS_DEF = 12;
  localparam int unsigned LINE_BITS_DEF   = 16;

  localparam logic KIND_TOKEN = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  localparam logic [2:0] TK_INDENT = 3'd0;
  localparam logic [2:0] TK_WS     = 3'd1;
  localparam logic [2:0] TK_KEY    = 3'd2;
  localparam logic [2:0] TK_NUM    = 3'd3;
  localparam logic [2:0] TK_LIT    = 3'd4;
  localparam logic [2:0] TK_SYM    = 3'd5;

  localparam logic ERR_TAB = 1'b0;
  localparam logic ERR_LIT = 1'b1;

  localparam logic [7:0] CH_POUND  = 8'h23;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  // character class from the front stage
  typedef struct packed {
    logic ws;
    logic tab;
    logic alpha;
    logic digit;
    logic dot;
    logic pound;
    logic quote;
    logic lt;
    logic bslash;
    logic sym_lead;
  } ch_class_t;

  function automatic ch_class_t classify(input logic [7:0] c);
    ch_class_t k;
    k.tab      = (c == CH_TAB);
    k.ws       = (c == CH_SPACE) || (c == CH_TAB);
    k.alpha    = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    k.digit    = (c >= 8'h30 && c <= 8'h39);
    k.dot      = (c == CH_DOT);
    k.pound    = (c == CH_POUND);
    k.quote    = (c == CH_DQUOTE) || (c == CH_SQUOTE);
    k.lt       = (c == CH_LT);
    k.bslash   = (c == CH_BSLASH);
    k.sym_lead = (c == CH_COLON) || (c == CH_LPAREN) || (c == CH_MINUS) ||
                 (c == CH_SLASH) || (c == CH_STAR);
    return k;
  endfunction

  function automatic logic sym_pair(input logic [7:0] a, input logic [7:0] b);
    return (a == CH_COLON && b == CH_COLON) || (a == CH_LPAREN && b == CH_RPAREN) ||
           (a == CH_MINUS && b == CH_GT) ||
           (a == CH_SLASH && (b == CH_SLASH || b == CH_STAR)) ||
           (a == CH_STAR && b == CH_SLASH);
  endfunction

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
    ch_class_t  cls;
  } front_item_t;

endpackage

@@ rtl/lost_if.sv @@
interface lost_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;
  modport source (output valid, output ch, output line_end, input ready);
  modport sink (input valid, input ch, input line_end, output ready);
endinterface

interface lost_out_if #(
  parameter int unsigned COLUMN_BITS = lost_pkg::COLUMN_BITS_DEF,
  parameter int unsigned LINE_BITS   = lost_pkg::LINE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [2:0]             token_kind;
  logic                   error_code;
  logic [LINE_BITS-1:0]   line_number;
  logic [COLUMN_BITS-1:0] column;
  logic [COLUMN_BITS-1:0] length;
  logic                   last;
  modport source (output valid, output kind, output token_kind, output error_code,
                  output line_number, output column, output length, output last,
                  input ready);
  modport sink (input valid, input kind, input token_kind, input error_code,
                input line_number, input column, input length, input last,
                output ready);
endinterface

@@ rtl/lost_front.sv @@
module lost_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_ch,
  input  logic                 in_line_end,
  output logic                 q_valid,
  input  logic                 q_ready,
  output lost_pkg::front_item_t q_item
);

  logic [1:0]             cnt_r;
  lost_pkg::front_item_t  buf_r [2];
  logic                   rd_r, wr_r;
  logic                   push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = buf_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_r].ch       <= in_ch;
      buf_r[wr_r].line_end <= in_line_end;
      buf_r[wr_r].cls      <= lost_pkg::classify(in_ch);
    end
  end

`ifndef SYNTH
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !in_ready) else $error("accepted while full");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 2'd1) else $error("count step");
`endif

endmodule

@@ rtl/lost_back.sv @@
module lost_back #(
  parameter int unsigned COLUMN_BITS = lost_pkg::COLUMN_BITS_DEF,
  parameter int unsigned LINE_BITS   = lost_pkg::LINE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  lost_pkg::front_item_t  q_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_kind,
  output logic [2:0]             out_token_kind,
  output logic                   out_error_code,
  output logic [LINE_BITS-1:0]   out_line_number,
  output logic [COLUMN_BITS-1:0] out_column,
  output logic [COLUMN_BITS-1:0] out_length,
  output logic                   out_last
);

  localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;
  localparam logic [LINE_BITS-1:0]   LN_MAX  = '1;
  localparam int unsigned RW = 1 + 3 + 1 + LINE_BITS + 2 * COLUMN_BITS + 1;

  typedef enum logic [3:0] {
    M_LSTART, M_INDENT, M_MID, M_WS, M_KEY, M_INT, M_FRAC,
    M_PSTART, M_PWORD, M_LIT, M_SYM
  } mode_t;

  typedef struct packed {
    logic                   kind;
    logic [2:0]             tk;
    logic                   ec;
    logic [LINE_BITS-1:0]   ln;
    logic [COLUMN_BITS-1:0] col;
    logic [COLUMN_BITS-1:0] len;
    logic                   last;
  } res_t;

  mode_t                  mode_r, mode_nxt;
  logic                   pound_r, pound_nxt;
  logic [COLUMN_BITS-1:0] colc_r, colc_nxt;
  logic [COLUMN_BITS-1:0] start_r, start_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic                   esc_r, esc_nxt;
  logic [7:0]             held_r, held_nxt;
  logic [7:0]             close_r, close_nxt;
  logic                   tabf_r, tabf_nxt;
  logic [COLUMN_BITS-1:0] tabc_r, tabc_nxt;

  // result queue, four deep so one item's burst fits beside a waiting one
  res_t       rq_r [4];
  logic [2:0] rcnt_r;
  logic [1:0] rrd_r, rwr_r;
  res_t       res [3];
  logic [1:0] nres;
  logic       go, pop;

  assign q_ready = (rcnt_r <= 3'd1) || ((rcnt_r == 3'd2) && out_ready);
  assign go      = q_valid && q_ready;
  assign out_valid = (rcnt_r != 3'd0);
  assign pop       = out_valid && out_ready;
  assign {out_kind, out_token_kind, out_error_code, out_line_number,
          out_column, out_length, out_last} = RW'(rq_r[rrd_r]);

  always_comb begin
    lost_pkg::ch_class_t    k;
    logic [7:0]             c;
    logic [COLUMN_BITS-1:0] tstart;
    logic                   do_begin;
    logic [COLUMN_BITS-1:0] run, lit;
    k = q_item.cls;
    c = q_item.ch;
    mode_nxt = mode_r; pound_nxt = pound_r; colc_nxt = colc_r; start_nxt = start_r;
    line_nxt = line_r; esc_nxt = esc_r; held_nxt = held_r; close_nxt = close_r;
    tabf_nxt = tabf_r; tabc_nxt = tabc_r;
    nres = 2'd0;
    tstart = start_r;
    do_begin = 1'b0;
    for (int i = 0; i < 3; i++) res[i] = '0;
    run = colc_r - start_r;
    lit = (run != '0) ? run - 1'b1 : '0;
    if (q_item.line_end) begin
      case (mode_r)
        M_LSTART: begin
          res[0] = '{lost_pkg::KIND_TOKEN, lost_pkg::TK_INDENT, 1'b0, line_r, '0, '0, 1'b0};
          nres = 2'd1;
        end
        M_INDENT: begin
          res[0] = '{lost_pkg::KIND_TOKEN, lost_pkg::TK_INDENT, 1'b0, line_r, start_r, run,
                     1'b0};
          res[1] = '{lost_pkg::KIND_ERROR, 3'd0, lost_pkg::ERR_TAB, line_r, tabc_r, '0, 1'b0};
          nres = tabf_r ? 2'd2 : 2'd1;
        end
        M_WS: begin
          res[0] = '{lost_pkg::KIND_TOKEN, lost_pkg::TK_WS, 1'b0, line_r, start_r, run, 1'b0};
          nres = 2'd1;
        end
        M_KEY, M_PWORD: begin
          res[0] = '{lost_pkg::KIND_TOKEN, lost_pkg::TK_KEY, 1'b0, line_r, start_r, run, 1'b0};
          nres = 2'd1;
        end
        M_INT, M_FRAC: begin
          res[0] = '{lost_pkg::KIND_TOKEN, lost_pkg::TK_NUM, 1'b0, line_r, start_r, run, 1'b0};
          nres = 2'd1;
        end
        M_PSTART, M_SYM: begin
          res[0] = '{lost_pkg::KIND_TOKEN, lost_pkg::TK_SYM, 1'b0, line_r, start_r,
                     COLUMN_BITS'(1), 1'b0};
          nres = 2'd1;
        end
        M_LIT: begin
          res[0] = '{lost_pkg::KIND_TOKEN, lost_pkg::TK_LIT, 1'b0, line_r, start_r, lit, 1'b0};
          res[1] = '{lost_pkg::KIND_ERROR, 3'd0, lost_pkg::ERR_LIT, line_r, start_r, '0, 1'b0};
          nres = 2'd2;
        end
        default: nres = 2'd0;
      endcase
      mode_nxt = M_LSTART; pound_nxt = 1'b0; esc_nxt = 1'b0; tabf_nxt = 1'b0;
      tabc_nxt = '0; colc_nxt = '0; start_nxt = '0;
      if (line_r != LN_MAX) line_nxt = line_r + 1'b1;
    end else begin
      case (mode_r)
        M_LSTART: begin
          start_nxt = '0;
          tstart = '0;
          if (k.ws) begin
            mode_nxt = M_INDENT;
            if (k.tab) begin
              tabf_nxt = 1'b1; tabc_nxt = colc_r;
            end
          end else begin
            res[0] = '{lost_pkg::KIND_TOKEN, lost_pkg::TK_INDENT, 1'b0, line_r, '0, '0, 1'b0};
            nres = 2'd1;
            do_begin = 1'b1;
          end
        end
        M_INDENT: begin
          if (k.ws) begin
            if (k.tab && !tabf_r) begin
              tabf_nxt = 1'b1; tabc_nxt = colc_r;
            end
          end else begin
            res[0] = '{lost_pkg::KIND_TOKEN, lost_pkg::TK_INDENT, 1'b0, line_r, start_r, run,
                       1'b0};
            res[1] = '{lost_pkg::KIND_ERROR, 3'd0, lost_pkg::ERR_TAB, line_r, tabc_r, '0,
                       1'b0};
            nres = tabf_r ? 2'd2 : 2'd1;
            do_begin = 1'b1;
          end
        end
        M_WS: if (!k.ws) begin
          res[0] = '{lost_pkg::KIND_TOKEN, lost_pkg::TK_WS, 1'b0, line_r, start_r, run, 1'b0};
          nres = 2'd1; do_begin = 1'b1;
        end
        M_KEY: if (!(k.alpha || k.digit)) begin
          res[0] = '{lost_pkg::KIND_TOKEN, lost_pkg::TK_KEY, 1'b0, line_r, start_r, run, 1'b0};
          nres = 2'd1; do_begin = 1'b1;
        end
        M_INT: begin
          if (k.dot) mode_nxt = M_FRAC;
          else if (!k.digit) begin
            res[0] = '{lost_pkg::KIND_TOKEN, lost_pkg::TK_NUM, 1'b0, line_r, start_r, run,
                       1'b0};
            nres = 2'd1; do_begin = 1'b1;
          end
        end
        M_FRAC: if (!k.digit) begin
          res[0] = '{lost_pkg::KIND_TOKEN, lost_pkg::TK_NUM, 1'b0, line_r, start_r, run, 1'b0};
          nres = 2'd1; do_begin = 1'b1;
        end
        M_PSTART: begin
          if (k.alpha || k.digit) mode_nxt = M_PWORD;
          else begin
            res[0] = '{lost_pkg::KIND_TOKEN, lost_pkg::TK_SYM, 1'b0, line_r, start_r,
                       COLUMN_BITS'(1), 1'b0};
            nres = 2'd1; do_begin = 1'b1;
          end
        end
        M_PWORD: if (!(k.alpha || k.digit)) begin
          res[0] = '{lost_pkg::KIND_TOKEN, lost_pkg::TK_KEY, 1'b0, line_r, start_r, run, 1'b0};
          nres = 2'd1; do_begin = 1'b1; pound_nxt = 1'b1;
        end
        M_LIT: begin
          if (esc_r) esc_nxt = 1'b0;
          else if (c == close_r) begin
            res[0] = '{lost_pkg::KIND_TOKEN, lost_pkg::TK_LIT, 1'b0, line_r, start_r, lit,
                       1'b0};
            nres = 2'd1; mode_nxt = M_MID;
          end else if (k.bslash) esc_nxt = 1'b1;
        end
        M_SYM: begin
          if (lost_pkg::sym_pair(held_r, c)) begin
            res[0] = '{lost_pkg::KIND_TOKEN, lost_pkg::TK_SYM, 1'b0, line_r, start_r,
                       COLUMN_BITS'(2), 1'b0};
            nres = 2'd1; mode_nxt = M_MID;
          end else begin
            res[0] = '{lost_pkg::KIND_TOKEN, lost_pkg::TK_SYM, 1'b0, line_r, start_r,
                       COLUMN_BITS'(1), 1'b0};
            nres = 2'd1; do_begin = 1'b1;
          end
        end
        default: do_begin = 1'b1;
      endcase
      // start a new token at the current column
      if (do_begin) begin
        start_nxt = colc_r;
        if (k.ws) mode_nxt = M_WS;
        else if (k.alpha) mode_nxt = M_KEY;
        else if (k.digit) mode_nxt = M_INT;
        else if (k.pound) mode_nxt = M_PSTART;
        else if (k.quote || (k.lt && pound_nxt)) begin
          close_nxt = k.lt ? lost_pkg::CH_GT : c;
          esc_nxt = 1'b0;
          mode_nxt = M_LIT;
        end else if (k.sym_lead) begin
          held_nxt = c;
          mode_nxt = M_SYM;
        end else begin
          res[nres] = '{lost_pkg::KIND_TOKEN, lost_pkg::TK_SYM, 1'b0, line_r, colc_r,
                        COLUMN_BITS'(1), 1'b0};
          nres = nres + 2'd1;
          mode_nxt = M_MID;
        end
      end
      if (tstart != start_r) start_nxt = do_begin ? colc_r : tstart;
      if (colc_r != COL_MAX) colc_nxt = colc_r + 1'b1;
    end
    if (nres != 2'd0) res[nres - 2'd1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_LSTART; pound_r <= 1'b0; colc_r <= '0; start_r <= '0;
      line_r <= LINE_BITS'(1); esc_r <= 1'b0; held_r <= '0; close_r <= '0;
      tabf_r <= 1'b0; tabc_r <= '0;
      rcnt_r <= 3'd0; rrd_r <= 2'd0; rwr_r <= 2'd0;
    end else begin
      if (go) begin
        mode_r <= mode_nxt; pound_r <= pound_nxt; colc_r <= colc_nxt;
        start_r <= start_nxt; line_r <= line_nxt; esc_r <= esc_nxt;
        held_r <= held_nxt; close_r <= close_nxt; tabf_r <= tabf_nxt;
        tabc_r <= tabc_nxt;
      end
      rwr_r  <= rwr_r + (go ? nres : 2'd0);
      if (pop) rrd_r <= rrd_r + 2'd1;
      rcnt_r <= rcnt_r + (go ? {1'b0, nres} : 3'd0) - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < nres) rq_r[rwr_r + 2'(i)] <= res[i];
      end
    end
  end

`ifndef SYNTH
  a_rq_bound: assert property (@(posedge clk) disable iff (!rst_n) rcnt_r <= 3'd4)
    else $error("result queue overflow");
  a_line_nz: assert property (@(posedge clk) disable iff (!rst_n) line_r != '0)
    else $error("line count zero");
  a_lstart_col: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == M_LSTART |-> colc_r == '0) else $error("line start off column zero");
`endif

endmodule

@@ rtl/line_oriented_source_tokenizer.sv @@
// Line tokenizer: takes one byte or one end-of-line item per cycle when not
// back-pressured and emits indent, whitespace, keyword, number, literal and
// symbol tokens plus error reports, up to three results per item with last
// on the final one. A two-entry input queue with character classification
// feeds the lexer state machine, which writes a four-entry result queue; the
// sustained rate is one item per cycle while results drain one per cycle, so
// a burst of multi-result items is limited by the single output port.
module line_oriented_source_tokenizer #(
  parameter int unsigned COLUMN_BITS = lost_pkg::COLUMN_BITS_DEF,
  parameter int unsigned LINE_BITS   = lost_pkg::LINE_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  lost_in_if.sink    in_ch_if,
  lost_out_if.source out_tok_if
);

  logic                  q_valid, q_ready;
  lost_pkg::front_item_t q_item;

  lost_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch_if.valid), .in_ready(in_ch_if.ready),
    .in_ch(in_ch_if.ch), .in_line_end(in_ch_if.line_end),
    .q_valid, .q_ready, .q_item
  );

  lost_back #(.COLUMN_BITS(COLUMN_BITS), .LINE_BITS(LINE_BITS)) u_back (
    .clk, .rst_n,
    .q_valid, .q_ready, .q_item,
    .out_valid(out_tok_if.valid), .out_ready(out_tok_if.ready),
    .out_kind(out_tok_if.kind), .out_token_kind(out_tok_if.token_kind),
    .out_error_code(out_tok_if.error_code), .out_line_number(out_tok_if.line_number),
    .out_column(out_tok_if.column), .out_length(out_tok_if.length),
    .out_last(out_tok_if.last)
  );

endmodule
